### sv/kiss_frame_codec_assert.svh
// ----------------------------------------------------------------------------
// kiss_frame_codec_assert.svh
// Assertion macros shared by the codec front and queue modules.
// ----------------------------------------------------------------------------
`ifndef KISS_FRAME_CODEC_ASSERT_SVH
`define KISS_FRAME_CODEC_ASSERT_SVH

// Condition must hold at every clock edge outside reset
`define KFC_ASSERT_ALWAYS(name, clk, rstn, cond) \
    name: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("kfc assertion failed");

// Consequent must hold in the cycle after the antecedent
`define KFC_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("kfc assertion failed");

`endif

### sv/kfc_pkg.sv
// ----------------------------------------------------------------------------
// kfc_pkg
// Types and constants of the KISS frame codec.
// ----------------------------------------------------------------------------
package kfc_pkg;

    // KISS special bytes
    localparam logic [7:0] FEND     = 8'hC0;
    localparam logic [7:0] FESC     = 8'hDB;
    localparam logic [7:0] TFEND    = 8'hDC;
    localparam logic [7:0] TFESC    = 8'hDD;
    localparam logic [7:0] CMD_MASK = 8'h0F;

    // Configuration register indexes
    localparam int unsigned    CFG_ADDR_W    = 2;
    localparam int unsigned    CFG_DATA_W    = 4;
    localparam logic [CFG_ADDR_W-1:0] CFG_DIRECTION = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_COMMAND   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SUPPRESS  = 2'd2;

    // Results per input word and queue sizing
    localparam int unsigned MAX_RES  = 5;
    localparam int unsigned RES_W    = 3;
    localparam int unsigned QDEPTH   = 2;
    localparam int unsigned QPTR_W   = 1;
    localparam int unsigned QCNT_W   = 2;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_OPEN    = 3'd1,
        ST_NO_CLOSE   = 3'd2,
        ST_SHORT      = 3'd3,
        ST_BAD_CMD    = 3'd4,
        ST_SUPPRESSED = 3'd5
    } kfc_status_t;

    typedef enum logic [1:0] {
        POS_START   = 2'd0,
        POS_COMMAND = 2'd1,
        POS_PAYLOAD = 2'd2,
        POS_SPARE   = 2'd3
    } kfc_pos_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } kfc_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_marker;
        logic [2:0] frame_status;
        logic       run_last;
    } kfc_out_t;

    // One queue entry: all results caused by one input word
    typedef struct packed {
        logic [RES_W-1:0]        count;
        logic [MAX_RES-1:0][7:0] bytes;
        logic                    is_marker;
        kfc_status_t             status;
    } kfc_entry_t;

endpackage

### sv/kfc_front.sv
// ----------------------------------------------------------------------------
// kfc_front
// Accepts input words, tracks frame state and builds the result list of
// each word for the queue. Holds the configuration registers.
// ----------------------------------------------------------------------------
module kfc_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [kfc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [kfc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  kfc_pkg::kfc_in_t             s_data,
    input  logic                         q_full,
    output logic                         q_push,
    output kfc_pkg::kfc_entry_t          q_entry
);
    import kfc_pkg::*;

    `include "kiss_frame_codec_assert.svh"

    logic        direction_reg;
    logic [3:0]  command_reg;
    logic        suppress_reg;
    kfc_pos_t    pos_reg, pos_next;
    logic        esc_reg, esc_next;
    kfc_status_t status_reg, status_next;

    logic        accept;
    logic [7:0]  b;
    logic        last;
    logic [7:0]  cmd_byte;
    kfc_pos_t    pos_eff;
    logic [RES_W-1:0] n;
    kfc_entry_t  ent;
    kfc_status_t st;

    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign b        = s_data.data_byte;
    assign last     = s_data.frame_end;
    assign cmd_byte = {4'b0000, command_reg} & CMD_MASK;
    assign pos_eff  = (pos_reg == POS_SPARE) ? POS_PAYLOAD : pos_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= 1'b0;
            command_reg   <= 4'd0;
            suppress_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_DIRECTION: direction_reg <= cfg_wdata[0];
                CFG_COMMAND:   command_reg   <= cfg_wdata;
                CFG_SUPPRESS:  suppress_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Build result list and next frame state
    always_comb begin
        ent         = '0;
        n           = '0;
        st          = ST_OK;
        pos_next    = pos_reg;
        esc_next    = esc_reg;
        status_next = status_reg;
        if (!direction_reg) begin
            // encode
            if (!suppress_reg) begin
                if (pos_eff == POS_START) begin
                    ent.bytes[n] = FEND;
                    n = n + 3'd1;
                    ent.bytes[n] = cmd_byte;
                    n = n + 3'd1;
                end
                if (b == FEND || b == FESC) begin
                    ent.bytes[n] = FESC;
                    n = n + 3'd1;
                    ent.bytes[n] = (b == FEND) ? TFEND : TFESC;
                    n = n + 3'd1;
                end else begin
                    ent.bytes[n] = b;
                    n = n + 3'd1;
                end
                if (last) begin
                    ent.bytes[n] = FEND;
                    n = n + 3'd1;
                end
            end
            if (last) begin
                pos_next    = POS_START;
                esc_next    = 1'b0;
                status_next = ST_OK;
            end else if (pos_reg == POS_START) begin
                pos_next = POS_COMMAND;
            end else if (pos_reg == POS_COMMAND) begin
                pos_next = POS_PAYLOAD;
            end
        end else if (last) begin
            // decode, closing byte: first error wins
            st = status_reg;
            if (pos_eff == POS_START && b != FEND && st == ST_OK) begin
                st = ST_NO_OPEN;
            end
            if (st == ST_OK && pos_eff != POS_PAYLOAD) begin
                st = ST_SHORT;
            end
            if (st == ST_OK && b != FEND) begin
                st = ST_NO_CLOSE;
            end
            if (st == ST_OK && suppress_reg) begin
                st = ST_SUPPRESSED;
            end
            ent.is_marker = 1'b1;
            ent.status    = st;
            n             = 3'd1;
            pos_next      = POS_START;
            esc_next      = 1'b0;
            status_next   = ST_OK;
        end else begin
            // decode, opening, command or payload byte
            priority if (pos_eff == POS_START) begin
                if (b != FEND && status_reg == ST_OK) begin
                    status_next = ST_NO_OPEN;
                end
                pos_next = POS_COMMAND;
            end else if (pos_eff == POS_COMMAND) begin
                if (b != cmd_byte && status_reg == ST_OK) begin
                    status_next = ST_BAD_CMD;
                end
                pos_next = POS_PAYLOAD;
            end else if (esc_reg) begin
                esc_next = 1'b0;
                if (!suppress_reg && (b == TFEND || b == TFESC)) begin
                    ent.bytes[0] = (b == TFEND) ? FEND : FESC;
                    n = 3'd1;
                end
            end else if (b == FESC) begin
                esc_next = 1'b1;
            end else begin
                if (!suppress_reg) begin
                    ent.bytes[0] = b;
                    n = 3'd1;
                end
            end
        end
        ent.count = n;
    end

    assign q_entry = ent;
    assign q_push  = accept && (n != '0);

    // Frame state advances on every accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= POS_START;
            esc_reg    <= 1'b0;
            status_reg <= ST_OK;
        end else if (accept) begin
            pos_reg    <= pos_next;
            esc_reg    <= esc_next;
            status_reg <= status_next;
        end
    end

    `KFC_ASSERT_NEXT(a_frame_end_clears, aclk, aresetn, accept && last,
        pos_reg == POS_START && !esc_reg && status_reg == ST_OK)

endmodule

### sv/kfc_queue.sv
// ----------------------------------------------------------------------------
// kfc_queue
// Short queue of result lists between the front and back parts.
// ----------------------------------------------------------------------------
module kfc_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  kfc_pkg::kfc_entry_t push_entry,
    input  logic                pop,
    output kfc_pkg::kfc_entry_t head,
    output logic                empty,
    output logic                full
);
    import kfc_pkg::*;

    `include "kiss_frame_codec_assert.svh"

    kfc_entry_t         ent_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == QCNT_W'(QDEPTH));
    assign head  = ent_reg[rd_ptr_reg];

    // Store pushed list
    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `KFC_ASSERT_ALWAYS(a_no_overflow, aclk, aresetn, !(push && full))
    `KFC_ASSERT_ALWAYS(a_no_underflow, aclk, aresetn, !(pop && empty))
    `KFC_ASSERT_NEXT(a_fill_tracks, aclk, aresetn, push && !pop,
        count_reg == $past(count_reg) + 1'b1)

endmodule

### sv/kfc_back.sv
// ----------------------------------------------------------------------------
// kfc_back
// Walks the head result list one word a cycle, while m_ready allows, into the output register.
// ----------------------------------------------------------------------------
module kfc_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  kfc_pkg::kfc_entry_t head,
    input  logic                empty,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output kfc_pkg::kfc_out_t   m_data
);
    import kfc_pkg::*;

    logic [RES_W-1:0] idx_reg;
    logic             m_valid_reg;
    kfc_out_t         m_data_reg;
    logic             load;
    logic             last_one;

    assign load     = !empty && (!m_valid_reg || m_ready);
    assign last_one = (idx_reg == head.count - 3'd1);
    assign pop      = load && last_one;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Output valid and list index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                idx_reg     <= last_one ? '0 : idx_reg + 3'd1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Output word
    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg.out_byte     <= head.bytes[idx_reg];
            m_data_reg.is_marker    <= head.is_marker;
            m_data_reg.frame_status <= head.status;
            m_data_reg.run_last     <= last_one;
        end
    end

endmodule

### sv/kiss_frame_codec.sv
// ----------------------------------------------------------------------------
// kiss_frame_codec
// KISS byte-stuffing encoder/decoder with end-of-frame status markers.
// ----------------------------------------------------------------------------
//  channel   dir  handshake           word
//  s_*       in   s_valid / s_ready   data_byte, frame_end
//  m_*       out  m_valid / m_ready   out_byte, is_marker, frame_status, run_last
//  cfg_*     in   cfg_wr_en           direction, command_code, suppress
//
//  A word is taken every cycle while the two-entry result queue has room.
//  Each word yields 0 to 5 output words, sent one per cycle from the output
//  register while m_ready is high; the front keeps taking words meanwhile.
//  Reset is synchronous, with no clearing pass.
//  A stall on m_ready fills the queue and then drops s_ready.
// ----------------------------------------------------------------------------
module kiss_frame_codec (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [kfc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [kfc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  kfc_pkg::kfc_in_t               s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output kfc_pkg::kfc_out_t              m_data
);
    import kfc_pkg::*;

    logic       q_push;
    logic       q_pop;
    logic       q_empty;
    logic       q_full;
    kfc_entry_t q_entry;
    kfc_entry_t q_head;

    kfc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    kfc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty),
        .full       (q_full)
    );

    kfc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (q_head),
        .empty   (q_empty),
        .pop     (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

### tb/tb_kiss_frame_codec.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_kiss_frame_codec
// Self-checking bench for the KISS frame codec. Directed frames cover the
// encoder escapes, every decoder status, bad escapes, suppress and mode
// changes inside a frame. Random frames then run under four idle/stall
// phases. A predictor tracks the codec state and compares every output word.
// ----------------------------------------------------------------------------
module tb_kiss_frame_codec;
    import kfc_pkg::*;

    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 8;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    kfc_in_t               s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    kfc_out_t              m_data;

    // Predictor copy of registers and frame state
    logic        cfg_dir = 1'b0;
    logic [3:0]  cfg_cmd = 4'h0;
    logic        cfg_sup = 1'b0;
    kfc_pos_t    codec_pos  = POS_START;
    logic        codec_esc  = 1'b0;
    kfc_status_t codec_pend = ST_OK;

    kfc_out_t    expected_words[$];
    kfc_out_t    step_words[MAX_RES];
    int          step_count;
    int          error_count    = 0;
    int          words_sent     = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;

    kiss_frame_codec uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Hard stop if the run hangs
    initial begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

    // Receiver back-pressure
    always @(negedge aclk) begin
        if (recv_stall_pct == 0) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic void emit(input logic [7:0] b, input logic marker,
                                 input kfc_status_t st);
        step_words[step_count].out_byte     = b;
        step_words[step_count].is_marker    = marker;
        step_words[step_count].frame_status = st;
        step_words[step_count].run_last     = 1'b0;
        step_count++;
    endfunction

    function automatic void clear_frame();
        codec_pos  = POS_START;
        codec_esc  = 1'b0;
        codec_pend = ST_OK;
    endfunction

    // Work out the output words caused by one accepted input word
    function automatic void predict_codec(input kfc_in_t w);
        kfc_pos_t    pos;
        kfc_status_t st;
        logic [7:0]  cmd_byte;
        cmd_byte   = 8'(cfg_cmd) & CMD_MASK;
        step_count = 0;
        if (!cfg_dir) begin
            // Encode: open, escape, close
            if (!cfg_sup) begin
                if (codec_pos == POS_START) begin
                    emit(FEND, 1'b0, ST_OK);
                    emit(cmd_byte, 1'b0, ST_OK);
                end
                if (w.data_byte == FEND) begin
                    emit(FESC, 1'b0, ST_OK);
                    emit(TFEND, 1'b0, ST_OK);
                end else if (w.data_byte == FESC) begin
                    emit(FESC, 1'b0, ST_OK);
                    emit(TFESC, 1'b0, ST_OK);
                end else begin
                    emit(w.data_byte, 1'b0, ST_OK);
                end
                if (w.frame_end) emit(FEND, 1'b0, ST_OK);
            end
            if (w.frame_end) begin
                clear_frame();
            end else if (codec_pos == POS_START) begin
                codec_pos = POS_COMMAND;
            end else if (codec_pos == POS_COMMAND) begin
                codec_pos = POS_PAYLOAD;
            end
        end else begin
            pos = (codec_pos == POS_SPARE) ? POS_PAYLOAD : codec_pos;
            if (w.frame_end) begin
                // Closing byte: first error wins
                st = codec_pend;
                if (pos == POS_START && w.data_byte != FEND && st == ST_OK) st = ST_NO_OPEN;
                if (st == ST_OK && pos != POS_PAYLOAD) st = ST_SHORT;
                if (st == ST_OK && w.data_byte != FEND) st = ST_NO_CLOSE;
                if (st == ST_OK && cfg_sup) st = ST_SUPPRESSED;
                emit(8'h00, 1'b1, st);
                clear_frame();
            end else if (pos == POS_START) begin
                if (w.data_byte != FEND && codec_pend == ST_OK) codec_pend = ST_NO_OPEN;
                codec_pos = POS_COMMAND;
            end else if (pos == POS_COMMAND) begin
                if (w.data_byte != cmd_byte && codec_pend == ST_OK) codec_pend = ST_BAD_CMD;
                codec_pos = POS_PAYLOAD;
            end else if (codec_esc) begin
                // Second byte of an escape; anything else is dropped
                codec_esc = 1'b0;
                if (!cfg_sup) begin
                    if (w.data_byte == TFEND) emit(FEND, 1'b0, ST_OK);
                    else if (w.data_byte == TFESC) emit(FESC, 1'b0, ST_OK);
                end
            end else if (w.data_byte == FESC) begin
                codec_esc = 1'b1;
            end else if (!cfg_sup) begin
                emit(w.data_byte, 1'b0, ST_OK);
            end
        end
        for (int i = 0; i < step_count; i++) begin
            step_words[i].run_last = (i == step_count - 1);
            expected_words.push_back(step_words[i]);
        end
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Compare each output word with the oldest expectation
    always @(posedge aclk) begin
        kfc_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, got %h", $time, m_data);
                error_count++;
            end else begin
                want = expected_words.pop_front();
                check_field("out_byte", want.out_byte, m_data.out_byte);
                check_field("is_marker", 8'(want.is_marker), 8'(m_data.is_marker));
                check_field("frame_status", 8'(want.frame_status), 8'(m_data.frame_status));
                check_field("run_last", 8'(want.run_last), 8'(m_data.run_last));
            end
        end
    end

    // Offer one input word and hold it until accepted
    task automatic send_word(input logic [7:0] b, input logic last);
        kfc_in_t w;
        w.data_byte = b;
        w.frame_end = last;
        @(negedge aclk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_codec(w);
        words_sent++;
    endtask

    // Drop valid and wait until every expected word has come out
    task automatic drain_codec();
        int waited;
        waited = 0;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_words.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (expected_words.size() != 0) begin
            $display("%0t: %0d expected words never arrived, expected %h, got none",
                     $time, expected_words.size(), expected_words[0]);
            error_count++;
            expected_words.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (addr)
            CFG_DIRECTION: cfg_dir = value[0];
            CFG_COMMAND:   cfg_cmd = value;
            CFG_SUPPRESS:  cfg_sup = value[0];
            default: ;
        endcase
    endtask

    task automatic send_bytes(input logic [7:0] bytes[$], input logic close);
        for (int i = 0; i < bytes.size(); i++) begin
            send_word(bytes[i], close && (i == bytes.size() - 1));
        end
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return FEND;
            1:       return FESC;
            2:       return TFEND;
            3:       return TFESC;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Escapes, both command extremes, suppress mid-frame
    task automatic test_encode_directed();
        write_cfg(CFG_DIRECTION, 4'd0);
        write_cfg(CFG_COMMAND, 4'd0);
        write_cfg(CFG_SUPPRESS, 4'd0);
        send_bytes('{FEND, FESC, 8'h00, 8'hFF}, 1'b1);
        drain_codec();
        write_cfg(CFG_COMMAND, 4'd15);
        send_word(8'hA5, 1'b1);
        drain_codec();
        // Suppressed first byte still advances the frame position
        write_cfg(CFG_SUPPRESS, 4'd1);
        send_word(8'h11, 1'b0);
        drain_codec();
        write_cfg(CFG_SUPPRESS, 4'd0);
        send_word(8'h22, 1'b1);
        drain_codec();
    endtask

    // Every frame status, bad escapes, bare FEND, suppress
    task automatic test_decode_directed();
        write_cfg(CFG_DIRECTION, 4'd1);
        write_cfg(CFG_COMMAND, 4'd5);
        send_bytes('{FEND, 8'h05, FESC, 8'h41, FEND, FESC, TFEND, FESC, TFESC, FESC, FEND},
                   1'b1);
        send_bytes('{8'h00, 8'h05, FEND}, 1'b1);
        send_bytes('{FEND, 8'h15, FEND}, 1'b1);
        send_bytes('{FEND}, 1'b1);
        send_bytes('{FEND, FEND}, 1'b1);
        send_bytes('{FEND, 8'h05, 8'h42}, 1'b1);
        drain_codec();
        write_cfg(CFG_SUPPRESS, 4'd1);
        send_bytes('{FEND, 8'h05, 8'h41, FEND}, 1'b1);
        drain_codec();
        write_cfg(CFG_SUPPRESS, 4'd0);
    endtask

    // Switch direction inside a frame; state carries over
    task automatic test_mode_change();
        write_cfg(CFG_DIRECTION, 4'd0);
        send_word(8'h41, 1'b0);
        drain_codec();
        write_cfg(CFG_DIRECTION, 4'd1);
        send_bytes('{8'h05, 8'h42, FEND}, 1'b1);
        send_word(FEND, 1'b0);
        drain_codec();
        write_cfg(CFG_DIRECTION, 4'd0);
        send_word(8'h07, 1'b1);
        drain_codec();
    endtask

    task automatic send_encode_frame();
        int len;
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) send_word(pick_byte(), i == len - 1);
    endtask

    // Well-formed KISS frames half the time, broken ones otherwise
    task automatic send_decode_frame();
        int         kind;
        int         len;
        logic [7:0] b;
        kind = $urandom_range(9);
        if (kind == 0) begin
            len = $urandom_range(1, 2);
            for (int i = 0; i < len; i++) send_word(pick_byte(), i == len - 1);
        end else begin
            send_word((kind == 1) ? pick_byte() : FEND, 1'b0);
            send_word((kind == 2) ? pick_byte() : (8'(cfg_cmd) & CMD_MASK), 1'b0);
            len = $urandom_range(0, 5);
            repeat (len) begin
                b = pick_byte();
                if (kind == 3) begin
                    send_word(b, 1'b0);
                end else if (b == FEND) begin
                    send_word(FESC, 1'b0);
                    send_word(TFEND, 1'b0);
                end else if (b == FESC) begin
                    send_word(FESC, 1'b0);
                    send_word(TFESC, 1'b0);
                end else begin
                    send_word(b, 1'b0);
                end
            end
            send_word((kind == 4) ? pick_byte() : FEND, 1'b1);
        end
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int count);
        int start;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start          = words_sent;
        while (words_sent - start < count) begin
            // Reconfigure between frames only, with the codec idle
            if ($urandom_range(3) == 0) begin
                drain_codec();
                write_cfg(CFG_DIRECTION, 4'($urandom_range(1)));
                write_cfg(CFG_COMMAND, 4'($urandom_range(15)));
                write_cfg(CFG_SUPPRESS, 4'($urandom_range(5) == 0));
            end
            if (cfg_dir) send_decode_frame();
            else send_encode_frame();
        end
        drain_codec();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_encode_directed();
        test_decode_directed();
        test_mode_change();
        test_random_traffic(0, 0, 30);
        test_random_traffic(88, 0, 30);
        test_random_traffic(0, 88, 30);
        test_random_traffic(23, 23, 30);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
